>>> design/partitioned_sorted_unique_insert_unit_assert.svh
// Assertion macros for the sorted unique insert unit.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef PARTITIONED_SORTED_UNIQUE_INSERT_UNIT_ASSERT_SVH
`define PARTITIONED_SORTED_UNIQUE_INSERT_UNIT_ASSERT_SVH

// same-cycle implication
`define PSUI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSUI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/psui_pkg.sv
// Shared types and constants for the sorted unique insert unit.
// No dependencies.
package psui_pkg;

  localparam int MAX_ENTRIES_DEF  = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam int CAP_W       = 7;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_RESP_FULL,
    S_RESP_DUP,
    S_RESP_INS
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    in_ready;
    logic    load;
    logic    init_search;
    logic    rd_en;
    logic    rd_shift;
    logic    step_idx;
    logic    init_shift;
    logic    wr_shift;
    logic    wr_ins;
    logic    emit;
    status_e emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic at_end;
    logic match;
    logic less;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

>>> design/psui_ctrl.sv
// Sequencer for the sorted unique insert unit: full check, scan, shift, insert, reply.
// Depends on psui_pkg.
module psui_ctrl
  import psui_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_CHECK;
      S_CHECK:     state_d = stat_i.full ? S_RESP_FULL : S_SRCH_RD;
      S_SRCH_RD:   state_d = stat_i.at_end ? S_SHIFT_RD : S_SRCH_CMP;
      S_SRCH_CMP: begin
        priority if (stat_i.match) state_d = S_RESP_DUP;
        else if (stat_i.less)      state_d = S_SHIFT_RD;
        else                       state_d = S_SRCH_RD;
      end
      S_SHIFT_RD:  state_d = stat_i.shift_done ? S_INSERT : S_SHIFT_WR;
      S_SHIFT_WR:  state_d = S_SHIFT_RD;
      S_INSERT:    state_d = S_RESP_INS;
      S_RESP_FULL,
      S_RESP_DUP,
      S_RESP_INS:  if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.emit_status = ST_INSERTED;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      S_CHECK: cmd_o.init_search = !stat_i.full;
      S_SRCH_RD: begin
        cmd_o.rd_en      = !stat_i.at_end;
        cmd_o.init_shift = stat_i.at_end;
      end
      S_SRCH_CMP: begin
        cmd_o.step_idx   = !stat_i.match && !stat_i.less;
        cmd_o.init_shift = !stat_i.match && stat_i.less;
      end
      S_SHIFT_RD: begin
        cmd_o.rd_en    = !stat_i.shift_done;
        cmd_o.rd_shift = 1'b1;
      end
      S_SHIFT_WR: cmd_o.wr_shift = 1'b1;
      S_INSERT:   cmd_o.wr_ins = 1'b1;
      S_RESP_FULL: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_status = ST_FULL;
      end
      S_RESP_DUP: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_status = ST_DUPLICATE;
      end
      S_RESP_INS: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_status = ST_INSERTED;
      end
      default: ;
    endcase
  end

endmodule

>>> design/psui_dp.sv
// Datapath: handle table memory, counts, capacity register, scan and shift
// pointers, output word register. Depends on psui_pkg.
module psui_dp
  import psui_pkg::*;
#(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [IN_TUSER_W-1:0]  in_tuser_i,
  input  logic                   cfg_valid_i,
  input  logic [CAP_W-1:0]       cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic [OUT_TUSER_W-1:0] out_tuser_o
);

  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int LW    = (CW > CAP_W) ? CW : CAP_W;
  localparam int EXT_W = (HANDLE_WIDTH > IN_TDATA_W) ? HANDLE_WIDTH : IN_TDATA_W;
  localparam int PAD_W = OUT_TDATA_W - POS_W - 2 * CNT_W;

  logic [HANDLE_WIDTH-1:0] mem_q [MAX_ENTRIES];
  logic [HANDLE_WIDTH-1:0] rd_q;
  logic [HANDLE_WIDTH-1:0] h_q;
  logic                    v6_q;
  logic [CAP_W-1:0]        cap_q;
  logic [CW-1:0]           total_q, v4_q, idx_q, j_q;
  logic [EXT_W-1:0]        h_ext;
  logic [CW-1:0]           hi, jm1;
  logic [IW-1:0]           rd_addr;
  logic [LW-1:0]           total_ext;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [POS_W-1:0]        out_pos_q;
  logic [CNT_W-1:0]        out_total_q, out_v4_q;

  assign h_ext     = EXT_W'(in_tdata_i);
  assign hi        = v6_q ? total_q : v4_q;
  assign jm1       = j_q - 1'b1;
  assign rd_addr   = cmd_i.rd_shift ? jm1[IW-1:0] : idx_q[IW-1:0];
  assign total_ext = LW'(total_q);

  assign stat_o.full       = (total_ext >= LW'(cap_q)) || (total_ext >= LW'(MAX_ENTRIES));
  assign stat_o.at_end     = (idx_q >= hi);
  assign stat_o.match      = (rd_q == h_q);
  assign stat_o.less       = (h_q < rd_q);
  assign stat_o.shift_done = (j_q == idx_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // table: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.wr_shift) begin
      mem_q[j_q[IW-1:0]] <= rd_q;
    end else if (cmd_i.wr_ins) begin
      mem_q[idx_q[IW-1:0]] <= h_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q  <= h_ext[HANDLE_WIDTH-1:0];
      v6_q <= in_tuser_i[0];
    end
    if (cmd_i.init_search) begin
      idx_q <= v6_q ? v4_q : '0;
    end else if (cmd_i.step_idx) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.init_shift) begin
      j_q <= total_q;
    end else if (cmd_i.wr_shift) begin
      j_q <= jm1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      total_q <= '0;
      v4_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.wr_ins) begin
        total_q <= total_q + 1'b1;
        if (!v6_q) begin
          v4_q <= v4_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_pos_q    <= (cmd_i.emit_status == ST_FULL) ? '0 : POS_W'(idx_q);
      out_total_q  <= CNT_W'(total_q);
      out_v4_q     <= CNT_W'(v4_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {{PAD_W{1'b0}}, out_v4_q, out_total_q, out_pos_q};
  assign out_tuser_o = out_status_q;

endmodule

>>> design/partitioned_sorted_unique_insert_unit.sv
// Top level of the sorted unique insert unit: sequencer plus datapath.
// Depends on psui_pkg, psui_ctrl, psui_dp.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid_i/tready_o     | tdata: peer_handle; tuser: is_ipv6
//  m_axis  | out | m_axis_tvalid_o/tready_i     | tdata: position, entry_count, ipv4_count
//          |     |                              | tuser: status
//  cfg     | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i: capacity
//
// One word at a time; the time per word grows with the entries scanned and the
// entries moved up, as every step goes through the single read and write port
// of the handle table. A full table answers without a scan.
// Reset clears the counts and loads capacity 64; the table needs no clearing pass.
// A stalled result holds in the output register; the next word is taken meanwhile.
module partitioned_sorted_unique_insert_unit
  import psui_pkg::*;
#(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] peer_handle
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,   // [0] is_ipv6
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [5:0] position, [12:6] entry_count,
                                                   // [19:13] ipv4_count, [23:20] zero
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,   // [1:0] status
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CAP_W-1:0]       cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign s_axis_tready_o = cmd.in_ready;
  assign cfg_ready_o     = 1'b1;

  psui_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psui_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o),
    .out_tuser_o (m_axis_tuser_o)
  );

endmodule

>>> design/psui_checker.sv
// Port-level checker for the sorted unique insert unit, bound to the top level.
// Depends on psui_pkg and partitioned_sorted_unique_insert_unit_assert.svh.
`include "partitioned_sorted_unique_insert_unit_assert.svh"

module psui_checker
  import psui_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CAP_W-1:0]       cfg_data_i
);

  // one word in flight: after taking a word the input closes
  `PSUI_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input accepted while a word is in flight")

  `PSUI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  `PSUI_ASSERT_NOW(a_status_code, m_axis_tvalid_o, m_axis_tuser_o == ST_INSERTED || m_axis_tuser_o == ST_DUPLICATE || m_axis_tuser_o == ST_FULL, "undefined status code")

  // a full table reports slot zero
  `PSUI_ASSERT_NOW(a_full_pos, m_axis_tvalid_o && m_axis_tuser_o == ST_FULL, m_axis_tdata_o[POS_W-1:0] == '0, "full result with nonzero position")

endmodule

bind partitioned_sorted_unique_insert_unit psui_checker u_psui_checker (.*);

>>> test/insert_result_checker.sv
// Checker for the sorted unique insert unit: watches the input, result and capacity channels.
// Predicts each result from its own copy of the table and compares it field by field.
// Depends on psui_pkg.
module insert_result_checker
  import psui_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,    // [31:0] peer_handle
  input  logic [IN_TUSER_W-1:0]  in_user_i,    // [0] is_ipv6
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,   // [5:0] position, [12:6] entry_count,
                                               // [19:13] ipv4_count
  input  logic [OUT_TUSER_W-1:0] out_user_i,   // [1:0] status
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CAP_W-1:0]       cfg_data_i,
  output int unsigned            outstanding_o,
  output int unsigned            fail_count_o
);

  localparam int unsigned SLOTS = MAX_ENTRIES_DEF;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] v4;
  } insert_result_t;

  logic [HANDLE_WIDTH_DEF-1:0] slot_copy [SLOTS];
  int unsigned    n_total;
  int unsigned    n_v4;
  logic [CAP_W-1:0] cap_q;
  insert_result_t awaited_results [$];
  int unsigned    fails;

  // Applies one word to the table copy and returns the result it should produce.
  function automatic insert_result_t predict_insert(input logic v6,
                                                    input logic [HANDLE_WIDTH_DEF-1:0] h);
    insert_result_t r;
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    int unsigned j;
    lim = (cap_q < SLOTS) ? cap_q : SLOTS;
    if (n_total >= lim) begin
      r.status = ST_FULL;
      r.pos    = '0;
      r.total  = n_total[CNT_W-1:0];
      r.v4     = n_v4[CNT_W-1:0];
      return r;
    end
    lo = v6 ? n_v4 : 0;
    hi = v6 ? n_total : n_v4;
    i = lo;
    while (i < hi) begin
      if (slot_copy[i] == h) begin
        r.status = ST_DUPLICATE;
        r.pos    = i[POS_W-1:0];
        r.total  = n_total[CNT_W-1:0];
        r.v4     = n_v4[CNT_W-1:0];
        return r;
      end
      if (h < slot_copy[i]) break;
      i++;
    end
    // everything above the insert point moves up, IPv6 region included
    for (j = n_total; j > i; j--) slot_copy[j] = slot_copy[j-1];
    slot_copy[i] = h;
    n_total++;
    if (!v6) n_v4++;
    r.status = ST_INSERTED;
    r.pos    = i[POS_W-1:0];
    r.total  = n_total[CNT_W-1:0];
    r.v4     = n_v4[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_failure(input string what, input insert_result_t want,
                              input insert_result_t got);
    fails++;
    if (fails <= 10)
      $display("%0t: %s: expected status %0d pos %0d total %0d v4 %0d, got status %0d pos %0d total %0d v4 %0d",
               $time, what, want.status, want.pos, want.total, want.v4,
               got.status, got.pos, got.total, got.v4);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    insert_result_t got;
    insert_result_t want;
    if (!rst_ni) begin
      n_total = 0;
      n_v4    = 0;
      cap_q   = CAP_RESET;
      fails   = 0;
      awaited_results.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status = status_e'(out_user_i[1:0]);
        got.pos    = out_data_i[5:0];
        got.total  = out_data_i[12:6];
        got.v4     = out_data_i[19:13];
        if (awaited_results.size() == 0) begin
          want = '0;
          note_failure("result word with nothing pending", want, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.pos !== want.pos ||
              got.total !== want.total || got.v4 !== want.v4)
            note_failure("result mismatch", want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_q = cfg_data_i;
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(predict_insert(in_user_i[0], in_data_i));
      outstanding_o <= awaited_results.size();
      fail_count_o  <= fails;
    end
  end

endmodule

>>> test/testbench.sv
// Top of the sorted unique insert unit test: clock, reset, stimulus and verdict.
// Depends on psui_pkg, partitioned_sorted_unique_insert_unit and insert_result_checker.
module testbench;
  import psui_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;  // cycles without any accepted word
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 270;   // spare cycles before the verdict

  typedef struct {
    logic        v6;
    logic [31:0] h;
  } peer_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CAP_W-1:0]       cfg_data = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_ready;
  int unsigned            outstanding;
  int unsigned            fail_count;

  int unsigned words_sent = 0;
  logic        in_steady = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  peer_t       handle_pool [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  partitioned_sorted_unique_insert_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  insert_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .in_data_i     (s_tdata),
    .in_user_i     (s_tuser),
    .out_valid_i   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_data_i    (m_tdata),
    .out_user_i    (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // Watchdog: any accepted word on any channel resets the count.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off so the input backs up.
  initial begin : result_sink
    int unsigned k;
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_sent >= 160) begin
        m_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_done <= 1'b1;
      end else begin
        m_tready <= in_steady || ($urandom_range(99) >= 14);
      end
    end
  end

  // Valid stays high between back-to-back words; it only drops for a gap.
  task automatic send_word(input logic v6, input logic [31:0] h);
    peer_t p;
    while (!in_steady && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    s_tuser  <= v6;
    do @(posedge clk_i); while (!s_tready);
    words_sent <= words_sent + 1;
    in_steady  <= (words_sent >= 300) && (words_sent < 420);
    p.v6 = v6;
    p.h  = h;
    handle_pool.push_back(p);
  endtask

  // Drops valid and lets every pending result come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [7];
    logic [31:0]      edge_vals [4];
    int unsigned      p;
    int unsigned      n;
    int unsigned      r;
    int unsigned      k;
    logic             v6;
    logic [31:0]      h;

    phase_caps = '{7'd12, 7'd5, 7'd30, 7'd127, 7'd48, 7'd64, 7'd100};
    edge_vals  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b1, 32'hFFFF_FFFF);
    // zero capacity: both families report full
    set_capacity(7'd0);
    send_word(1'b0, 32'h0000_0001);
    send_word(1'b1, 32'h0000_0001);
    // small capacity: IPv4 insert shifts the IPv6 region, duplicates, then full
    set_capacity(7'd4);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b1, 32'h8000_0000);
    send_word(1'b0, 32'h0000_0000);
    // capacity lowered below the count
    set_capacity(7'd2);
    send_word(1'b0, 32'h5555_5555);
    send_word(1'b1, 32'hAAAA_AAAA);
    // capacity above the table size
    set_capacity(7'd127);
    send_word(1'b0, 32'h7FFF_FFFF);
    send_word(1'b1, 32'h1234_5678);
    send_word(1'b0, 32'h1234_5678);
    send_word(1'b1, 32'h1234_5678);
    send_word(1'b0, 32'h7FFF_FFFF);
    send_word(1'b1, 32'h0000_0001);
    send_word(1'b0, 32'h8000_0000);
    send_word(1'b1, 32'hAAAA_AAAA);
    send_word(1'b0, 32'h5555_5555);

    // random phases; mostly reused handles so duplicates hit a populated table
    for (p = 0; p < 7; p++) begin
      set_capacity(phase_caps[p]);
      for (n = 0; n < 105; n++) begin
        r = $urandom_range(99);
        if (r < 60) begin
          k  = $urandom_range(handle_pool.size() - 1);
          v6 = handle_pool[k].v6 ^ ($urandom_range(99) < 10);
          h  = handle_pool[k].h;
        end else if (r < 75) begin
          v6 = 1'($urandom_range(1));
          h  = $urandom_range(15);
        end else if (r < 83) begin
          v6 = 1'($urandom_range(1));
          h  = edge_vals[$urandom_range(3)];
        end else begin
          v6 = 1'($urandom_range(1));
          h  = $urandom;
        end
        send_word(v6, h);
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
